@@ hdl/icao_coordinate_pair_parser_core_macros.svh @@
// ============================================================================
// Assertion macros for the coordinate pair parser
// Shared concurrent assertion forms; NO_ASSERTIONS compiles them away.
// ============================================================================
`ifndef ICAO_COORDINATE_PAIR_PARSER_CORE_MACROS_SVH
`define ICAO_COORDINATE_PAIR_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion, disabled while the active-low reset is asserted.
`define ICPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ICPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ICPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ICPP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hdl/icpp_pkg.sv @@
// ============================================================================
// icpp_pkg
// Types and constants shared by the coordinate pair parser modules.
// ============================================================================
`timescale 1ns / 1ps

package icpp_pkg;

    // Widths of the text byte and of the result fields.
    localparam int CHAR_W  = 8;
    localparam int LAT_W   = 20;
    localparam int LON_W   = 21;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int DCNT_W  = 4;
    localparam int NDIGITS = 7;

    // Packed stream widths.
    localparam int M_DATA_W = 56;
    localparam int S_DATA_W = 8;

    // Seven stored decimal digits of the open token.
    typedef logic [NDIGITS-1:0][3:0] digits_t;

    // Outcome of decoding one closed token.
    typedef struct packed {
        logic                    ok;
        logic signed [LON_W-1:0] value;
    } dec_t;

    // One result item.
    typedef struct packed {
        logic                    pair_valid;
        logic signed [LAT_W-1:0] lat_arcsec;
        logic signed [LON_W-1:0] lon_arcsec;
        logic [IDX_W-1:0]        pair_index;
        logic                    end_of_text;
        logic [CNT_W-1:0]        pair_total;
    } res_t;

endpackage

@@ hdl/icpp_decode.sv @@
// ============================================================================
// icpp_decode
// Turns the digits of a closed token into signed arc-seconds and checks it.
// ============================================================================
`timescale 1ns / 1ps

module icpp_decode (
    input  icpp_pkg::digits_t             digits,
    input  logic [icpp_pkg::DCNT_W-1:0]   digit_count,
    input  logic                          is_latitude,
    input  logic                          negative,
    output icpp_pkg::dec_t                dec
);

    localparam int VAL_W = 22;
    localparam logic [VAL_W-1:0] LAT_MAX = VAL_W'(324000);
    localparam logic [VAL_W-1:0] LON_MAX = VAL_W'(648000);
    localparam logic [6:0]       SIXTY   = 7'd60;

    // Two decimal digits to a binary value below one hundred.
    function automatic logic [6:0] two_dig(input logic [3:0] hi, input logic [3:0] lo);
        two_dig = 7'(hi) * 7'd10 + 7'(lo);
    endfunction

    logic              count_ok;
    logic              has_sec;
    logic [9:0]        deg;
    logic [6:0]        mn;
    logic [6:0]        sc;
    logic [VAL_W-1:0]  mag;
    logic [VAL_W-1:0]  lim;
    logic signed [icpp_pkg::LON_W-1:0] pos;

    // Field layout depends on the hemisphere kind and the digit count.
    always_comb begin
        if (is_latitude) begin
            count_ok = (digit_count == 4'd4) || (digit_count == 4'd6);
            has_sec  = (digit_count == 4'd6);
            deg      = 10'(two_dig(digits[0], digits[1]));
            mn       = two_dig(digits[2], digits[3]);
            sc       = has_sec ? two_dig(digits[4], digits[5]) : 7'd0;
            lim      = LAT_MAX;
        end else begin
            count_ok = (digit_count == 4'd5) || (digit_count == 4'd7);
            has_sec  = (digit_count == 4'd7);
            deg      = 10'(digits[0]) * 10'd100 + 10'(two_dig(digits[1], digits[2]));
            mn       = two_dig(digits[3], digits[4]);
            sc       = has_sec ? two_dig(digits[5], digits[6]) : 7'd0;
            lim      = LON_MAX;
        end
    end

    // Arc-seconds from degrees, minutes and seconds.
    assign mag = VAL_W'(deg) * VAL_W'(3600) + VAL_W'(mn) * VAL_W'(60) + VAL_W'(sc);
    assign pos = $signed(mag[icpp_pkg::LON_W-1:0]);

    assign dec.ok    = count_ok && (mn < SIXTY) && (sc < SIXTY) && (mag <= lim);
    assign dec.value = negative ? -pos : pos;

endmodule

@@ hdl/icpp_scan.sv @@
// ============================================================================
// icpp_scan
// Per-byte token scanner: tracks the open token, holds the latitude and
// forms the result item for each byte.
// ============================================================================
`timescale 1ns / 1ps
`include "icao_coordinate_pair_parser_core_macros.svh"

module icpp_scan #(
    parameter int PAIR_LIMIT = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [icpp_pkg::CHAR_W-1:0]   char_code,
    input  logic                          last_char,
    input  logic [icpp_pkg::CNT_W-1:0]    max_pairs,
    output logic                          has_result,
    output icpp_pkg::res_t                res
);

    localparam int LIM_W = ($clog2(PAIR_LIMIT + 1) > icpp_pkg::CNT_W) ?
                           $clog2(PAIR_LIMIT + 1) : icpp_pkg::CNT_W;

    // Text state.
    logic                                 after_space_reg, after_space_next;
    logic                                 token_reg, token_next;
    logic                                 is_lat_reg, is_lat_next;
    logic                                 neg_reg, neg_next;
    logic [icpp_pkg::DCNT_W-1:0]          count_reg, count_next;
    icpp_pkg::digits_t                    store_reg, store_next;
    logic                                 held_reg, held_next;
    logic signed [icpp_pkg::LAT_W-1:0]    held_lat_reg, held_lat_next;
    logic [icpp_pkg::CNT_W-1:0]           pairs_reg, pairs_next;

    logic [icpp_pkg::CHAR_W-1:0] up;
    logic       is_ws, is_digit, is_hemi, start, close, emit;
    logic [LIM_W-1:0] limit;
    icpp_pkg::dec_t   dec;

    // Character classes; letters folded to upper case.
    always_comb begin
        up       = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ? char_code - 8'h20 : char_code;
        is_ws    = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));
        is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
        is_hemi  = (up == 8'h4E) || (up == 8'h53) || (up == 8'h45) || (up == 8'h57);
        start    = !token_reg && after_space_reg && is_hemi;
    end

    // Effective pair limit.
    assign limit = (LIM_W'(max_pairs) < LIM_W'(PAIR_LIMIT)) ? LIM_W'(max_pairs)
                                                             : LIM_W'(PAIR_LIMIT);

    // Token tracking: digits are stored, a new token opens on a hemisphere letter.
    always_comb begin
        store_next = store_reg;
        count_next = count_reg;
        is_lat_next = is_lat_reg;
        neg_next    = neg_reg;
        if (token_reg && is_digit) begin
            if (count_reg < 4'd7) begin
                store_next[count_reg[2:0]] = char_code[3:0];
            end
            if (count_reg < 4'd8) begin
                count_next = count_reg + 4'd1;
            end
        end else if (start) begin
            is_lat_next = (up == 8'h4E) || (up == 8'h53);
            neg_next    = (up == 8'h53) || (up == 8'h57);
            count_next  = '0;
        end
    end

    // A token closes on a non-digit or at the end of the text.
    assign close = token_reg ? (!is_digit || last_char) : (start && last_char);

    icpp_decode u_decode (
        .digits      (store_next),
        .digit_count (count_next),
        .is_latitude (is_lat_next),
        .negative    (neg_next),
        .dec         (dec)
    );

    // Latitude holding, pairing and the result item.
    always_comb begin
        held_next     = held_reg;
        held_lat_next = held_lat_reg;
        emit          = 1'b0;
        token_next    = close ? 1'b0 : (token_reg || start);
        if (close && dec.ok) begin
            if (is_lat_next) begin
                held_next     = 1'b1;
                held_lat_next = dec.value[icpp_pkg::LAT_W-1:0];
            end else if (held_reg && (LIM_W'(pairs_reg) < limit)) begin
                emit      = 1'b1;
                held_next = 1'b0;
            end
        end
        pairs_next       = emit ? pairs_reg + 7'd1 : pairs_reg;
        after_space_next = is_ws;

        res.pair_valid  = emit;
        res.lat_arcsec  = emit ? held_lat_reg : '0;
        res.lon_arcsec  = emit ? dec.value : '0;
        res.pair_index  = emit ? pairs_reg[icpp_pkg::IDX_W-1:0] : '0;
        res.end_of_text = last_char;
        res.pair_total  = pairs_next;
        has_result      = emit || last_char;
    end

    // State registers; the end of a text returns them to their start values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_space_reg <= 1'b1;
            token_reg       <= 1'b0;
            is_lat_reg      <= 1'b0;
            neg_reg         <= 1'b0;
            count_reg       <= '0;
            held_reg        <= 1'b0;
            held_lat_reg    <= '0;
            pairs_reg       <= '0;
        end else if (step) begin
            if (last_char) begin
                after_space_reg <= 1'b1;
                token_reg       <= 1'b0;
                is_lat_reg      <= 1'b0;
                neg_reg         <= 1'b0;
                count_reg       <= '0;
                held_reg        <= 1'b0;
                held_lat_reg    <= '0;
                pairs_reg       <= '0;
            end else begin
                after_space_reg <= after_space_next;
                token_reg       <= token_next;
                is_lat_reg      <= is_lat_next;
                neg_reg         <= neg_next;
                count_reg       <= count_next;
                held_reg        <= held_next;
                held_lat_reg    <= held_lat_next;
                pairs_reg       <= pairs_next;
            end
        end
    end

    // Digit store carries no reset; only digits of the open token are read.
    always_ff @(posedge aclk) begin
        if (step) begin
            store_reg <= store_next;
        end
    end

    `ICPP_ASSERT(a_count_sat, aclk, aresetn, count_reg <= 4'd8, "digit count above saturation")
    `ICPP_ASSERT(a_emit_clears_held, aclk, aresetn, (step && emit && !last_char) |=> !held_reg, "latitude still held after a pair")
    `ICPP_ASSERT(a_text_end_clear, aclk, aresetn, (step && last_char) |=> (pairs_reg == '0) && !token_reg && after_space_reg, "state not cleared after last byte")
    `ICPP_ASSERT(a_emit_needs_held, aclk, aresetn, emit |-> held_reg, "pair emitted without a held latitude")

endmodule

@@ hdl/icao_coordinate_pair_parser_core.sv @@
// ============================================================================
// icao_coordinate_pair_parser_core
// Scans a byte stream for hemisphere-prefixed coordinate tokens and emits
// latitude/longitude pairs in signed arc-seconds.
//
//   Channel  Ports            Contents (low bit first)
//   -------  ---------------  ----------------------------------------------
//   input    s_t*             tdata: char_code; tlast: last_char
//   result   m_t*             tdata: lat, lon, pair_index, pair_total;
//                             tuser: pair_valid; tlast: end_of_text
//   config   cfg_we/cfg_wdata max_pairs
//
// One byte is taken per cycle unless the output register is full and not
// taken. A byte passes an input register and then the scanner and decoder,
// whose result lands in the output register. The input register holds while
// the output register is full and not taken. Reset is synchronous and sets
// max_pairs to 64.
// ============================================================================
`timescale 1ns / 1ps
`include "icao_coordinate_pair_parser_core_macros.svh"

module icao_coordinate_pair_parser_core #(
    parameter int PAIR_LIMIT = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration
    input  logic                              cfg_we,
    input  logic [icpp_pkg::CNT_W-1:0]        cfg_wdata,     // max_pairs
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [icpp_pkg::S_DATA_W-1:0]     s_tdata,       // [7:0] char_code
    input  logic                              s_tlast,       // last_char
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [19:0] lat_arcsec, [40:20] lon_arcsec, [46:41] pair_index,
    // [53:47] pair_total, [55:54] zero
    output logic [icpp_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tuser,       // pair_valid
    output logic                              m_tlast        // end_of_text
);

    logic [icpp_pkg::CNT_W-1:0]  max_pairs_reg;
    logic                        in_valid_reg;
    logic [icpp_pkg::CHAR_W-1:0] in_char_reg;
    logic                        in_last_reg;
    logic                        out_valid_reg;
    icpp_pkg::res_t              out_res_reg;
    icpp_pkg::res_t              res;
    logic                        has_result;
    logic                        advance;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pairs_reg <= 7'd64;
        end else if (cfg_we) begin
            max_pairs_reg <= cfg_wdata;
        end
    end

    // The held byte moves on when the output register can take its result.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata[icpp_pkg::CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    icpp_scan #(
        .PAIR_LIMIT (PAIR_LIMIT)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .char_code  (in_char_reg),
        .last_char  (in_last_reg),
        .max_pairs  (max_pairs_reg),
        .has_result (has_result),
        .res        (res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.pair_valid;
    assign m_tlast  = out_res_reg.end_of_text;
    assign m_tdata  = {2'b00,
                       out_res_reg.pair_total,
                       out_res_reg.pair_index,
                       out_res_reg.lon_arcsec,
                       out_res_reg.lat_arcsec};

    `ICPP_ASSERT(a_result_loaded, aclk, aresetn, (advance && has_result) |=> out_valid_reg, "result lost on load")
    `ICPP_ASSERT(a_index_total, aclk, aresetn, (out_valid_reg && out_res_reg.pair_valid) |-> (out_res_reg.pair_total[5:0] == out_res_reg.pair_index + 6'd1), "pair total does not follow pair index")
    `ICPP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !out_valid_reg && !in_valid_reg, "registers not empty after reset")

endmodule

@@ bench/icao_coordinate_pair_parser_core_tb.sv @@
// ============================================================================
// Coordinate pair parser testbench
// Feeds text bytes into the parser and checks every result against a
// predictor that tracks the scan state, the held latitude and the pair count.
// Covers field extremes, rejected tokens, the pair limit, back-pressure and
// random texts under several max_pairs settings.
// ============================================================================
`timescale 1ns / 1ps

module icao_coordinate_pair_parser_core_tb;

    localparam int PAIR_LIMIT      = 64;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int MAX_REPORTS     = 10;
    // Byte budget for the random texts, spread over the phases.
    localparam int RANDOM_BYTES    = 240;
    localparam int RANDOM_PHASES   = 8;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_GAP         = 10;
    localparam int DIGIT_CNT_SAT   = 8;
    localparam int RESET_MAX_PAIRS = 64;
    localparam int LAT_LIMIT       = 324000;
    localparam int LON_LIMIT       = 648000;
    localparam int LIMIT_TEXT_PAIRS = 66;
    localparam int TRAIL_NOISE     = 12;

    // Bit positions of the result fields inside m_tdata.
    localparam int LON_LSB = icpp_pkg::LAT_W;
    localparam int IDX_LSB = LON_LSB + icpp_pkg::LON_W;
    localparam int TOT_LSB = IDX_LSB + icpp_pkg::IDX_W;
    localparam int PAD_LSB = TOT_LSB + icpp_pkg::CNT_W;
    localparam int PAD_W   = icpp_pkg::M_DATA_W - PAD_LSB;

    // Character codes.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_N        = 8'h4E;
    localparam logic [7:0] CH_S        = 8'h53;
    localparam logic [7:0] CH_W        = 8'h57;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [icpp_pkg::CNT_W-1:0]    cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [icpp_pkg::S_DATA_W-1:0] s_tdata;      // [7:0] char_code
    logic                          s_tlast;      // last_char
    logic                          m_tvalid;
    logic                          m_tready;
    // [19:0] lat, [40:20] lon, [46:41] pair_index, [53:47] pair_total, [55:54] zero
    logic [icpp_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;      // pair_valid
    logic                          m_tlast;      // end_of_text

    icao_coordinate_pair_parser_core #(
        .PAIR_LIMIT(PAIR_LIMIT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Scanner state as the parser should hold it.
    logic [icpp_pkg::CNT_W-1:0] max_pairs_q;
    bit                         after_ws;
    bit                         in_token;
    bit                         tok_is_lat;
    bit                         tok_neg;
    int                         digit_cnt;
    logic [3:0]                 digits [icpp_pkg::NDIGITS];
    bit                         lat_held;
    int                         held_lat;
    logic [icpp_pkg::CNT_W-1:0] pairs_emitted;

    icpp_pkg::res_t results_due[$];
    logic [7:0]     text_bytes[$];

    bit sender_idles;
    bit receiver_idles;
    int ready_gap;
    int hold_off_left;

    int fail_count;
    int chars_sent;
    int texts_sent;
    int results_seen;
    int pairs_seen;
    int cfg_writes;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #(10_000_000);
        $display("Timeout: the run did not finish in time.");
        $display("FAILURE");
        $finish;
    end

    function automatic bit is_space_char(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int digit_pair(input int at);
        return int'(digits[at]) * 10 + int'(digits[at + 1]);
    endfunction

    function automatic void clear_text();
        after_ws      = 1'b1;
        in_token      = 1'b0;
        tok_is_lat    = 1'b0;
        tok_neg       = 1'b0;
        digit_cnt     = 0;
        lat_held      = 1'b0;
        held_lat      = 0;
        pairs_emitted = '0;
    endfunction

    // Turn the stored digits into signed arc-seconds; returns 0 when the token is rejected.
    function automatic bit decode_token(output int value);
        int deg_w;
        int deg;
        int mins;
        int secs;
        int lim;
        value = 0;
        if (tok_is_lat) begin
            if (digit_cnt != 4 && digit_cnt != 6) return 1'b0;
            deg_w = 2;
            deg   = digit_pair(0);
            lim   = LAT_LIMIT;
        end else begin
            if (digit_cnt != 5 && digit_cnt != 7) return 1'b0;
            deg_w = 3;
            deg   = int'(digits[0]) * 100 + digit_pair(1);
            lim   = LON_LIMIT;
        end
        mins = digit_pair(deg_w);
        secs = (digit_cnt == deg_w + 4) ? digit_pair(deg_w + 2) : 0;
        if (mins >= 60 || secs >= 60) return 1'b0;
        value = deg * 3600 + mins * 60 + secs;
        if (value > lim) return 1'b0;
        if (tok_neg) value = -value;
        return 1'b1;
    endfunction

    // Close the open token; a latitude is held, a longitude may complete a pair.
    function automatic bit close_token(output int lat, output int lon);
        int v;
        int limit;
        lat      = 0;
        lon      = 0;
        limit    = (max_pairs_q < PAIR_LIMIT) ? int'(max_pairs_q) : PAIR_LIMIT;
        in_token = 1'b0;
        if (!decode_token(v)) return 1'b0;
        if (tok_is_lat) begin
            held_lat = v;
            lat_held = 1'b1;
            return 1'b0;
        end
        if (lat_held && pairs_emitted < limit) begin
            lat      = held_lat;
            lon      = v;
            lat_held = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the scanner by one byte; returns 1 when the byte yields a result.
    function automatic bit scan_char(input logic [7:0] c, input bit last,
                                     output icpp_pkg::res_t r);
        logic [7:0] u;
        bit         emit;
        int         lat;
        int         lon;
        u    = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFFSET : c;
        emit = 1'b0;
        lat  = 0;
        lon  = 0;
        r    = '0;
        if (in_token) begin
            if (is_digit_char(c)) begin
                if (digit_cnt < icpp_pkg::NDIGITS) digits[digit_cnt] = 4'(c - CH_ZERO);
                if (digit_cnt < DIGIT_CNT_SAT) digit_cnt++;
            end else begin
                emit = close_token(lat, lon);
            end
        end else if (after_ws && (u == CH_N || u == CH_S || u == CH_E || u == CH_W)) begin
            in_token   = 1'b1;
            tok_is_lat = (u == CH_N || u == CH_S);
            tok_neg    = (u == CH_S || u == CH_W);
            digit_cnt  = 0;
        end
        after_ws = is_space_char(c);
        // A token still open on the final byte is decoded right here.
        if (last && in_token) emit = close_token(lat, lon);
        if (emit) begin
            r.pair_index  = pairs_emitted[icpp_pkg::IDX_W-1:0];
            pairs_emitted = pairs_emitted + 1'b1;
        end
        r.pair_valid  = emit;
        r.lat_arcsec  = lat[icpp_pkg::LAT_W-1:0];
        r.lon_arcsec  = lon[icpp_pkg::LON_W-1:0];
        r.end_of_text = last;
        r.pair_total  = pairs_emitted;
        if (last) clear_text();
        return emit || last;
    endfunction

    // Result check: every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        icpp_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser) pairs_seen++;
            ready_gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] result with nothing predicted: valid=%0d tdata=%0h last=%0d",
                             $realtime, m_tuser, m_tdata, m_tlast);
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.pair_valid ||
                    m_tdata[icpp_pkg::LAT_W-1:0] !== want.lat_arcsec ||
                    m_tdata[LON_LSB +: icpp_pkg::LON_W] !== want.lon_arcsec ||
                    m_tdata[IDX_LSB +: icpp_pkg::IDX_W] !== want.pair_index ||
                    m_tdata[TOT_LSB +: icpp_pkg::CNT_W] !== want.pair_total ||
                    m_tdata[PAD_LSB +: PAD_W] !== '0 ||
                    m_tlast !== want.end_of_text) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display({"[%0t] mismatch: expected valid=%0d lat=%0d lon=%0d",
                                  " idx=%0d eot=%0d total=%0d"},
                                 $realtime, want.pair_valid, want.lat_arcsec,
                                 want.lon_arcsec, want.pair_index, want.end_of_text,
                                 want.pair_total);
                        $display({"    got valid=%0d lat=%0d lon=%0d idx=%0d eot=%0d",
                                  " total=%0d pad=%0h"},
                                 m_tuser, $signed(m_tdata[icpp_pkg::LAT_W-1:0]),
                                 $signed(m_tdata[LON_LSB +: icpp_pkg::LON_W]),
                                 m_tdata[IDX_LSB +: icpp_pkg::IDX_W], m_tlast,
                                 m_tdata[TOT_LSB +: icpp_pkg::CNT_W],
                                 m_tdata[PAD_LSB +: PAD_W]);
                    end
                end
            end
        end
    end

    // Result-side ready: random gaps per result, plus a long hold-off on request.
    initial begin : result_ready_drive
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else if (ready_gap > 0) begin
                m_tready <= 1'b0;
                ready_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Send one byte as a request; called and returning at a falling edge.
    task automatic send_char(input logic [7:0] c, input bit last);
        int             gap;
        icpp_pkg::res_t r;
        gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (scan_char(c, last, r)) results_due.push_back(r);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s, input bit close_text);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], close_text && i == s.len() - 1);
        if (close_text) texts_sent++;
    endtask

    // Send the built text; pause_at >= 0 waits for all results before that byte.
    task automatic send_buffer(input int pause_at);
        for (int i = 0; i < text_bytes.size(); i++) begin
            if (i == pause_at) wait_drained();
            send_char(text_bytes[i], i == text_bytes.size() - 1);
        end
        texts_sent++;
    endtask

    // Stop offering requests and wait until every predicted result has arrived.
    task automatic wait_drained();
        int waited;
        waited   = 0;
        s_tvalid <= 1'b0;
        while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_max_pairs(input logic [icpp_pkg::CNT_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        max_pairs_q = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task automatic hold_off_receiver(input int cycles);
        @(posedge aclk);
        hold_off_left = cycles;
        @(negedge aclk);
    endtask

    // Text builders.
    function automatic void put_digits(input int value, input int count);
        int p;
        p = 1;
        repeat (count - 1) p *= 10;
        for (int i = 0; i < count; i++) begin
            text_bytes.push_back(CH_ZERO + 8'((value / p) % 10));
            p /= 10;
        end
    endfunction

    function automatic void put_gap();
        int sel;
        sel = $urandom_range(0, 19);
        // Sometimes a non-space byte closes the token first.
        if (sel == 0) text_bytes.push_back(8'($urandom_range(0, 255)));
        else if (sel == 1) text_bytes.push_back(8'h2C);
        if ($urandom_range(0, 2) == 0)
            text_bytes.push_back(CH_TAB + 8'($urandom_range(0, 4)));
        else
            text_bytes.push_back(CH_SPACE);
        if ($urandom_range(0, 4) == 0) text_bytes.push_back(CH_SPACE);
    endfunction

    function automatic void put_noise(input int count);
        repeat (count) text_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // The shortest valid pair: a four-digit latitude and a five-digit longitude.
    function automatic void put_short_pair();
        text_bytes.push_back($urandom_range(0, 1) ? CH_S : CH_N);
        put_digits($urandom_range(0, 89), 2);
        put_digits($urandom_range(0, 59), 2);
        text_bytes.push_back(CH_SPACE);
        text_bytes.push_back($urandom_range(0, 1) ? CH_W : CH_E);
        put_digits($urandom_range(0, 179), 3);
        put_digits($urandom_range(0, 59), 2);
        text_bytes.push_back(CH_SPACE);
    endfunction

    // One hemisphere token; a bad one is broken in one of several ways.
    function automatic void put_coord(input bit lat, input bit good);
        int         deg_w;
        int         deg;
        int         mins;
        int         secs;
        int         count;
        bit         neg;
        bit         scramble;
        logic [7:0] letter;
        deg_w    = lat ? 2 : 3;
        deg      = lat ? $urandom_range(0, 89) : $urandom_range(0, 179);
        mins     = $urandom_range(0, 59);
        secs     = $urandom_range(0, 59);
        count    = deg_w + ($urandom_range(0, 1) ? 4 : 2);
        neg      = $urandom_range(0, 1);
        scramble = 1'b0;
        if ($urandom_range(0, 19) == 0) begin
            deg  = lat ? 90 : 180;
            mins = 0;
            secs = 0;
        end
        if (!good) begin
            case ($urandom_range(0, 4))
                0: begin
                    scramble = 1'b1;
                    do count = $urandom_range(0, 9);
                    while (count == deg_w + 2 || count == deg_w + 4);
                end
                1: mins = $urandom_range(60, 99);
                2: begin
                    secs  = $urandom_range(60, 99);
                    count = deg_w + 4;
                end
                3: begin
                    deg  = lat ? 90 : 180;
                    mins = $urandom_range(1, 59);
                end
                default: deg = lat ? $urandom_range(91, 99) : $urandom_range(181, 999);
            endcase
        end
        letter = lat ? (neg ? CH_S : CH_N) : (neg ? CH_W : CH_E);
        if ($urandom_range(0, 1)) letter = letter + CASE_OFFSET;
        text_bytes.push_back(letter);
        if (scramble) begin
            repeat (count) text_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            put_digits(deg, deg_w);
            put_digits(mins, 2);
            if (count == deg_w + 4) put_digits(secs, 2);
        end
    endfunction

    // A random text: mostly lat/lon pairs, with stray tokens, broken tokens and noise.
    function automatic void build_random_text();
        int n;
        int sel;
        text_bytes.delete();
        if ($urandom_range(0, 29) == 0) begin
            put_noise(1);
            return;
        end
        n = $urandom_range(1, 10);
        if ($urandom_range(0, 3) == 0) begin
            put_noise($urandom_range(1, 4));
            put_gap();
        end
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                put_coord(1'b1, 1'b1);
                put_gap();
                put_coord(1'b0, 1'b1);
            end else if (sel < 65) begin
                put_coord(1'b1, 1'b1);
            end else if (sel < 73) begin
                put_coord(1'b0, 1'b1);
            end else if (sel < 88) begin
                put_coord($urandom_range(0, 1), 1'b0);
            end else begin
                put_noise($urandom_range(1, 6));
            end
            // Half the texts end right on their last item, with no gap after it.
            if (k != n - 1 || $urandom_range(0, 1)) put_gap();
        end
    endfunction

    // Field extremes at the reset value of max_pairs, lower and upper case.
    task automatic test_extremes();
        send_text("S9000 W18000", 1'b1);
        send_text("n895959 e1795959 ", 1'b1);
        send_text("N900000\tE1800000", 1'b1);
    endtask

    // Rejected tokens, a replaced latitude and a letter that follows no space.
    task automatic test_rejected_tokens();
        send_text("E00100 N9001 E18001 N1260 N123460 N123 E123456 S0200 N0100 xE00300 E00300",
                  1'b1);
    endtask

    // A zero byte inside the text, and texts of a single byte.
    task automatic test_zero_byte();
        send_text("N0000", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_text(" W00000", 1'b1);
        send_char(CH_N, 1'b1);
        send_char(CH_NUL, 1'b1);
    endtask

    // Pair limit at zero and one; the latitude after the limit stays held.
    task automatic test_small_limits();
        set_max_pairs(7'd0);
        send_text("N0000 E00000", 1'b1);
        set_max_pairs(7'd1);
        send_text("N0100 E00100 N0200 E00200 ", 1'b1);
    endtask

    // One text with more pairs than PAIR_LIMIT allows; max_pairs is set above it.
    task automatic test_pair_limit();
        set_max_pairs(7'd127);
        text_bytes.delete();
        repeat (LIMIT_TEXT_PAIRS) put_short_pair();
        send_buffer(-1);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        set_max_pairs(7'd64);
        sender_idles   = 1'b0;
        receiver_idles = 1'b1;
        hold_off_receiver(HOLD_OFF_CYCLES);
        build_random_text();
        put_gap();
        put_coord(1'b1, 1'b1);
        put_gap();
        put_coord(1'b0, 1'b1);
        // Bytes after the pair pile up behind the waiting result.
        put_gap();
        put_noise(TRAIL_NOISE);
        send_buffer(-1);
    endtask

    // Sender stops in the middle of a token until all results are in.
    task automatic test_sender_pause();
        sender_idles = 1'b1;
        text_bytes.delete();
        put_coord(1'b1, 1'b1);
        put_gap();
        put_coord(1'b0, 1'b1);
        put_gap();
        put_coord(1'b1, 1'b1);
        send_buffer(3);
    endtask

    // Random texts over several max_pairs settings and idling mixes.
    task automatic test_random_texts();
        int start;
        int pause_at;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_max_pairs(7'd1);
                1: set_max_pairs(7'd2);
                2: set_max_pairs(7'd64);
                3: set_max_pairs(7'd0);
                4: set_max_pairs(7'd127);
                5: set_max_pairs(7'd3);
                default: set_max_pairs(7'($urandom_range(1, 64)));
            endcase
            sender_idles   = (p % 3 != 1) && (p != 6);
            receiver_idles = (p % 3 != 2) && (p != 6);
            start = chars_sent;
            while (chars_sent - start < RANDOM_BYTES / RANDOM_PHASES) begin
                build_random_text();
                pause_at = ($urandom_range(0, 29) == 0) ?
                           $urandom_range(0, text_bytes.size() - 1) : -1;
                send_buffer(pause_at);
            end
        end
    endtask

    initial begin : stimulus
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        ready_gap      = 0;
        hold_off_left  = 0;
        fail_count     = 0;
        chars_sent     = 0;
        texts_sent     = 0;
        results_seen   = 0;
        pairs_seen     = 0;
        cfg_writes     = 0;
        max_pairs_q    = 7'(RESET_MAX_PAIRS);
        for (int i = 0; i < icpp_pkg::NDIGITS; i++) digits[i] = '0;
        clear_text();

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes();
        test_rejected_tokens();
        test_zero_byte();
        test_small_limits();
        test_pair_limit();
        test_backpressure();
        test_sender_pause();
        test_random_texts();

        wait_drained();
        repeat (10) @(negedge aclk);
        if (results_due.size() != 0) begin
            $display("%0d predicted results never arrived.", results_due.size());
            fail_count += results_due.size();
        end
        if (fail_count > MAX_REPORTS)
            $display("%0d mismatches in total, later ones not shown.", fail_count);

        $display("Run covered %0d bytes in %0d texts with %0d max_pairs writes.",
                 chars_sent, texts_sent, cfg_writes);
        $display("Checked %0d results, %0d of them carrying a coordinate pair.",
                 results_seen, pairs_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
